// ===== sv/fmn_pkg.sv =====
// Shared constants, types and the sequencer state encoding for the modular factorial block.
package fmn_pkg;

    localparam int          MODULUS_W      = 32;
    localparam int unsigned MODULUS_RESET  = 32'd1000000007;
    localparam int          COUNT_BITS_DEF = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_FINISH
    } t_state;

    // Request from the sequencer to the multiply-reduce unit.
    typedef struct packed {
        logic                 start;
        logic [MODULUS_W-1:0] operand;
    } t_mm_req;

    // Response from the multiply-reduce unit.
    typedef struct packed {
        logic                 done;
        logic [MODULUS_W-1:0] result;
    } t_mm_rsp;

endpackage

// ===== sv/fmn_count_if.sv =====
// Valid/ready channel that carries the input count.
interface fmn_count_if #(
    parameter int COUNT_BITS = fmn_pkg::COUNT_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] count;

    modport source (output valid, output count, input ready);
    modport sink   (input valid, input count, output ready);
endinterface

// ===== sv/fmn_result_if.sv =====
// Valid/ready channel that carries the factorial result.
interface fmn_result_if;
    logic                           valid;
    logic                           ready;
    logic [fmn_pkg::MODULUS_W-1:0]  result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

// ===== sv/fmn_mulmod.sv =====
// Shared multiply-reduce unit: one multiply, then a bit-serial restoring reduction.
module fmn_mulmod #(
    parameter int COUNT_BITS = fmn_pkg::COUNT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fmn_pkg::t_mm_req               i_req,
    input  logic [COUNT_BITS-1:0]          i_mult,
    input  logic [fmn_pkg::MODULUS_W-1:0]  i_modulus,
    output fmn_pkg::t_mm_rsp               o_rsp
);
    import fmn_pkg::*;

    localparam int PW = MODULUS_W + COUNT_BITS;
    localparam int CW = $clog2(PW + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [PW-1:0]        r_prod;
    logic [MODULUS_W-1:0] r_rem;

    logic [MODULUS_W:0]   w_div;
    logic [MODULUS_W:0]   w_shift;
    logic [MODULUS_W:0]   w_diff;
    logic [MODULUS_W-1:0] w_next;

    // A zero modulus acts as 2^32, which keeps the low 32 bits of the product.
    always_comb begin
        w_div   = {(i_modulus == '0), i_modulus};
        w_shift = {r_rem, r_prod[PW-1]};
        w_diff  = w_shift - w_div;
        if (w_shift >= w_div) begin
            w_next = w_diff[MODULUS_W-1:0];
        end else begin
            w_next = w_shift[MODULUS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_prod <= PW'(i_req.operand) * PW'(i_mult);
                r_rem  <= '0;
                r_cnt  <= CW'(PW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= w_next;
                r_prod <= r_prod << 1;
                r_cnt  <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_rem;

endmodule

// ===== sv/factorial_mod_n.sv =====
// Top level of the modular factorial block: sequencer, modulus register and result register.
//
//   Channel   Direction  Payload                     Transfer when
//   i_count   in         count [COUNT_BITS-1:0]      valid && ready
//   o_result  out        result [31:0]               valid && ready
//   i_cfg_*   in         modulus [31:0]              i_cfg_we
//
// A count of m runs m multiply-reduce steps, or fewer when the product reaches
// zero early: every step runs one multiply followed by a one-bit-per-cycle
// reduction of the 32+COUNT_BITS bit product in the shared multiply-reduce
// unit. A count of zero skips the multiply-reduce unit.
// Reset is synchronous and active low; the modulus returns to 1000000007.
// The input is not ready while an item is in progress. A finished result waits
// in the output register, and the next count may be taken while it waits.
module factorial_mod_n #(
    parameter int COUNT_BITS = fmn_pkg::COUNT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fmn_pkg::MODULUS_W-1:0]  i_cfg_wdata,
    fmn_count_if.sink                      i_count,
    fmn_result_if.source                   o_result
);
    import fmn_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [MODULUS_W-1:0]  r_modulus;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    logic [COUNT_BITS-1:0] r_idx;
    logic [COUNT_BITS-1:0] n_idx;
    logic [MODULUS_W-1:0]  r_prod;
    logic [MODULUS_W-1:0]  n_prod;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [MODULUS_W-1:0]  r_out_result;
    logic [MODULUS_W-1:0]  n_out_result;

    t_mm_req               w_req;
    t_mm_rsp               w_rsp;
    logic                  w_in_xfer;
    logic                  w_out_xfer;

    fmn_mulmod #(
        .COUNT_BITS (COUNT_BITS)
    ) u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .i_mult    (r_idx),
        .i_modulus (r_modulus),
        .o_rsp     (w_rsp)
    );

    assign i_count.ready   = (r_state == ST_IDLE);
    assign w_in_xfer       = i_count.valid && i_count.ready;
    assign w_out_xfer      = r_out_valid && o_result.ready;
    assign o_result.valid  = r_out_valid;
    assign o_result.result = r_out_result;

    // The sequencer walks the multiplier from 1 up to the count. It stops early
    // when the product reaches zero, since every later step would keep it there.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_prod       = r_prod;
        n_out_valid  = r_out_valid;
        n_out_result = r_out_result;
        w_req.start   = 1'b0;
        w_req.operand = r_prod;

        if (w_out_xfer) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_count = i_count.count;
                    n_idx   = COUNT_BITS'(1);
                    n_prod  = MODULUS_W'(1);
                    // A count of zero gives 1 with no reduction at all.
                    if (i_count.count == '0) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_START;
                    end
                end
            end
            ST_START: begin
                w_req.start = 1'b1;
                n_state     = ST_WAIT;
            end
            ST_WAIT: begin
                if (w_rsp.done) begin
                    n_prod = w_rsp.result;
                    if ((w_rsp.result == '0) || (r_idx == r_count)) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_idx   = r_idx + COUNT_BITS'(1);
                        n_state = ST_START;
                    end
                end
            end
            ST_FINISH: begin
                // The result register must be empty or emptying this cycle.
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_result = r_prod;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_modulus   <= MODULUS_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_count      <= n_count;
        r_idx        <= n_idx;
        r_prod       <= n_prod;
        r_out_result <= n_out_result;
    end

endmodule
